// ===== hdl/power_of_two_bucket_allocator_core_macros.svh =====
// assertion macros for the power-of-two bucket allocator
// expects clk and rst_n in the scope where a macro is used
`ifndef POWER_OF_TWO_BUCKET_ALLOCATOR_CORE_MACROS_SVH
`define POWER_OF_TWO_BUCKET_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define P2BA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define P2BA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/p2ba_pkg.sv =====
// shared types and constants for the power-of-two bucket allocator
// no dependencies
`timescale 1ns / 1ps

package p2ba_pkg;

  localparam int SIZE_W      = 21;
  localparam int BADDR_W     = 20;
  localparam int OADDR_W     = 20;
  localparam int STAT_W      = 3;
  localparam int OCLS_W      = 5;
  localparam int CLSF_W      = 6;
  localparam int REG_W       = 21;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 32;
  localparam int OUT_PAD_W   = OUT_TDATA_W - STAT_W - OADDR_W - OCLS_W;

  localparam int CARVE_LIMIT = 12;
  localparam int CARVE_EXTRA = 2;
  localparam int N_W         = $clog2(CARVE_LIMIT + CARVE_EXTRA);
  localparam int PROD_W      = CARVE_LIMIT + N_W;
  localparam int HDR_BYTES   = 24;
  localparam int ALIGN_LOG   = 3;
  localparam int ALIGN_BYTES = 8;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_START = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'b1;
  localparam logic [REG_W-1:0]     REGION_END_RST   = 21'h100000;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK        = 3'd0,
    STAT_NO_SPACE  = 3'd1,
    STAT_TOO_LARGE = 3'd2,
    STAT_BAD_MARK  = 3'd3,
    STAT_CORRUPT   = 3'd4
  } status_t;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_DECODE = 8'b0000_0100,
    S_HRD    = 8'b0000_1000,
    S_CHECK  = 8'b0001_0000,
    S_CARVE  = 8'b0010_0000,
    S_FRD    = 8'b0100_0000,
    S_FPUSH  = 8'b1000_0000
  } state_t;

  // smallest class c >= 1 with size <= 2^c
  function automatic logic [CLSF_W-1:0] size_to_class(input logic [SIZE_W-1:0] size);
    logic [SIZE_W-1:0] m1;
    logic [CLSF_W-1:0] c;
    m1 = size - SIZE_W'(1);
    c  = CLSF_W'(1);
    if (size > SIZE_W'(2)) begin
      for (int i = 1; i < SIZE_W; i++) begin
        if (m1[i]) begin
          c = CLSF_W'(i + 1);
        end
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/power_of_two_bucket_allocator_core.sv =====
// power-of-two bucket allocator: header store and class heads in two rams
// depends on p2ba_pkg, p2ba_ram and the assertion macro header
// steps from accept: pop decode, header read; free decode, header read, push; carve decode,
// space check, one header write per block (up to 13); too large, zero or misaligned free end in decode,
// out of space in the space check, bad mark and corrupt entry in a header read; one item in flight
// reset: synchronous, then a clearing pass over all 2^(ADDR_W-3) headers (131072), in_tready low
`timescale 1ns / 1ps
`include "power_of_two_bucket_allocator_core_macros.svh"

module power_of_two_bucket_allocator_core #(
  parameter int ADDR_W      = 20,
  parameter int NUM_CLASSES = 20
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // request_size [20:0], block_address [40:21], zero pad
  input  logic [p2ba_pkg::IN_TDATA_W-1:0]    in_tdata,
  // operation
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // status [2:0], address [22:3], size_class [27:23], zero pad
  output logic [p2ba_pkg::OUT_TDATA_W-1:0]   out_tdata,
  input  logic                               cfg_wr_en,
  input  logic [p2ba_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [p2ba_pkg::REG_W-1:0]         cfg_wr_data
);

  import p2ba_pkg::*;

  localparam int IDX_W     = ADDR_W - ALIGN_LOG;
  localparam int CLS_W     = $clog2(NUM_CLASSES);
  localparam int BP_W      = (ADDR_W + 1 > REG_W + 1) ? ADDR_W + 1 : REG_W + 1;
  localparam int SUM_W     = BP_W + 1;
  localparam int BLK_W     = ADDR_W + 1;
  localparam int HDR_DEPTH = 1 << IDX_W;

  typedef struct packed {
    logic [IDX_W-1:0]  nidx;
    logic              nvld;
    logic [CLSF_W-1:0] cls;
    logic              mark;
  } hdr_t;

  localparam int HDR_W = $bits(hdr_t);

  state_t                   state_r, state_nxt;
  logic [IDX_W-1:0]         clr_r, clr_nxt;
  logic                     op_r, op_nxt;
  logic [CLSF_W-1:0]        pow_r, pow_nxt;
  logic                     big_r, big_nxt;
  logic [ADDR_W-1:0]        addr_r, addr_nxt;
  logic [CLS_W-1:0]         cls_r, cls_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic [BP_W-1:0]          bp_r, bp_nxt;
  logic [REG_W-1:0]         rend_r, rend_nxt;
  logic [NUM_CLASSES-1:0]   hvld_r, hvld_nxt;
  logic [ADDR_W-1:0]        base_r, base_nxt;
  logic [ADDR_W-1:0]        a_r, a_nxt;
  logic [BLK_W-1:0]         blk_r, blk_nxt;
  logic [N_W-1:0]           n_r, n_nxt;
  logic [N_W-1:0]           k_r, k_nxt;
  logic                     out_tvalid_r, out_tvalid_nxt;
  logic [OUT_TDATA_W-1:0]   out_tdata_r, out_tdata_nxt;

  // header ram
  logic                     hd_we;
  logic [IDX_W-1:0]         hd_waddr;
  hdr_t                     hd_wdata;
  logic [IDX_W-1:0]         hd_raddr;
  hdr_t                     hd_rd;

  // class head ram
  logic                     hl_we;
  logic [CLS_W-1:0]         hl_waddr;
  logic [IDX_W-1:0]         hl_wdata;
  logic [CLS_W-1:0]         hl_raddr;
  logic [IDX_W-1:0]         hl_rdata;

  logic                        out_free;
  logic [CLSF_W-1:0]           pow_in;
  logic [ADDR_W+BADDR_W-1:0]   addr_in_ext;
  logic [ADDR_W-1:0]           hdr_a;
  logic [ADDR_W-1:0]           pop_addr;
  logic [BLK_W-1:0]            pw_oh;
  logic [BLK_W-1:0]            blk;
  logic [N_W-1:0]              n_c;
  logic [PROD_W-1:0]           prod;
  logic [SUM_W-1:0]            total;
  logic [SUM_W-1:0]            lim;
  logic [SUM_W-1:0]            rend_ext;
  logic [SUM_W-1:0]            end_eff;
  logic [SUM_W-1:0]            bp_sum;
  logic                        no_space;
  logic [BLK_W-1:0]            first_nxt;
  logic [BLK_W-1:0]            a_sum;
  logic                        k_last;
  logic [BP_W-1:0]             reload;
  logic                        fin;
  status_t                     fin_status;
  logic [ADDR_W-1:0]           fin_addr;
  logic [CLSF_W-1:0]           fin_cls;
  logic [ADDR_W+OADDR_W-1:0]   fin_addr_ext;

  p2ba_ram #(
    .WIDTH (HDR_W),
    .DEPTH (HDR_DEPTH)
  ) u_hdr_ram (
    .clk     (clk),
    .wr_en   (hd_we),
    .wr_addr (hd_waddr),
    .wr_data (hd_wdata),
    .rd_addr (hd_raddr),
    .rd_data (hd_rd)
  );

  p2ba_ram #(
    .WIDTH (IDX_W),
    .DEPTH (NUM_CLASSES)
  ) u_head_ram (
    .clk     (clk),
    .wr_en   (hl_we),
    .wr_addr (hl_waddr),
    .wr_data (hl_wdata),
    .rd_addr (hl_raddr),
    .rd_data (hl_rdata)
  );

  // datapath
  always_comb begin
    out_free    = !out_tvalid_r || out_tready;
    pow_in      = size_to_class(in_tdata[SIZE_W-1:0]);
    addr_in_ext = {{ADDR_W{1'b0}}, in_tdata[SIZE_W +: BADDR_W]};
    hdr_a       = addr_r - ADDR_W'(HDR_BYTES);
    pop_addr    = {idx_r, {ALIGN_LOG{1'b0}}} + ADDR_W'(HDR_BYTES);

    // block footprint and carve size
    pw_oh    = BLK_W'(1) << pow_r;
    blk      = ((pow_r < CLSF_W'(ALIGN_LOG)) ? BLK_W'(ALIGN_BYTES) : pw_oh)
               + BLK_W'(HDR_BYTES);
    n_c      = (pow_r < CLSF_W'(CARVE_LIMIT)) ?
               N_W'(CARVE_LIMIT + CARVE_EXTRA) - N_W'(pow_r) : N_W'(1);
    prod     = PROD_W'(blk[CARVE_LIMIT-1:0]) * PROD_W'(n_c);
    total    = (pow_r < CLSF_W'(CARVE_LIMIT)) ? SUM_W'(prod) : SUM_W'(blk);
    lim      = SUM_W'(1) << ADDR_W;
    rend_ext = SUM_W'(rend_r);
    end_eff  = (rend_ext < lim) ? rend_ext : lim;
    bp_sum   = SUM_W'(bp_r) + total;
    no_space = (pow_r >= CLSF_W'(ADDR_W)) || (bp_sum > end_eff);
    first_nxt = {1'b0, bp_r[ADDR_W-1:0]} + blk;

    a_sum  = {1'b0, a_r} + blk_r;
    k_last = (k_r == n_r - N_W'(1));
    reload = BP_W'(cfg_wr_data) + BP_W'(ALIGN_BYTES - 1);
    reload = {reload[BP_W-1:ALIGN_LOG], {ALIGN_LOG{1'b0}}};
  end

  // read address selection
  always_comb begin
    unique case (state_r)
      S_IDLE:  hl_raddr = pow_in[CLS_W-1:0];
      S_FRD:   hl_raddr = hd_rd.cls[CLS_W-1:0];
      default: hl_raddr = cls_r;
    endcase
    if (state_r == S_DECODE) begin
      hd_raddr = (op_r == OP_ALLOC) ? hl_rdata : hdr_a[ADDR_W-1:ALIGN_LOG];
    end else begin
      hd_raddr = idx_r;
    end
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    op_nxt         = op_r;
    pow_nxt        = pow_r;
    big_nxt        = big_r;
    addr_nxt       = addr_r;
    cls_nxt        = cls_r;
    idx_nxt        = idx_r;
    bp_nxt         = bp_r;
    rend_nxt       = rend_r;
    hvld_nxt       = hvld_r;
    base_nxt       = base_r;
    a_nxt          = a_r;
    blk_nxt        = blk_r;
    n_nxt          = n_r;
    k_nxt          = k_r;
    out_tvalid_nxt = out_tvalid_r;
    out_tdata_nxt  = out_tdata_r;
    hd_we          = 1'b0;
    hd_waddr       = idx_r;
    hd_wdata       = '0;
    hl_we          = 1'b0;
    hl_waddr       = cls_r;
    hl_wdata       = '0;
    fin            = 1'b0;
    fin_status     = STAT_OK;
    fin_addr       = '0;
    fin_cls        = '0;

    unique case (state_r)
      S_CLEAR: begin
        hd_we    = 1'b1;
        hd_waddr = clr_r;
        clr_nxt  = clr_r + IDX_W'(1);
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt    = in_tuser;
          pow_nxt   = pow_in;
          big_nxt   = (pow_in >= CLSF_W'(NUM_CLASSES));
          addr_nxt  = addr_in_ext[ADDR_W-1:0];
          cls_nxt   = pow_in[CLS_W-1:0];
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (op_r == OP_ALLOC) begin
          priority if (big_r) begin
            fin        = out_free;
            fin_status = STAT_TOO_LARGE;
          end else if (hvld_r[cls_r]) begin
            idx_nxt   = hl_rdata;
            state_nxt = S_HRD;
          end else begin
            state_nxt = S_CHECK;
          end
        end else begin
          priority if (addr_r == '0) begin
            fin = out_free;
          end else if (hdr_a[ALIGN_LOG-1:0] != '0) begin
            fin        = out_free;
            fin_status = STAT_BAD_MARK;
          end else begin
            idx_nxt   = hdr_a[ADDR_W-1:ALIGN_LOG];
            state_nxt = S_FRD;
          end
        end
      end
      S_HRD: begin
        fin     = out_free;
        fin_cls = pow_r;
        if (hd_rd.mark) begin
          // list entry still marked allocated: drop the whole list
          fin_status = STAT_CORRUPT;
          if (out_free) begin
            hvld_nxt[cls_r] = 1'b0;
          end
        end else begin
          fin_addr = pop_addr;
          if (out_free) begin
            hl_we           = 1'b1;
            hl_wdata        = hd_rd.nidx;
            hvld_nxt[cls_r] = hd_rd.nvld;
            hd_we           = 1'b1;
            hd_wdata.mark   = 1'b1;
            hd_wdata.cls    = pow_r;
          end
        end
      end
      S_CHECK: begin
        if (no_space) begin
          fin        = out_free;
          fin_status = STAT_NO_SPACE;
          fin_cls    = pow_r;
        end else begin
          base_nxt  = bp_r[ADDR_W-1:0];
          a_nxt     = bp_r[ADDR_W-1:0];
          blk_nxt   = blk;
          n_nxt     = n_c;
          k_nxt     = '0;
          bp_nxt    = bp_sum[BP_W-1:0];
          state_nxt = S_CARVE;
          if (n_c != N_W'(1)) begin
            hl_we           = 1'b1;
            hl_wdata        = first_nxt[ADDR_W-1:ALIGN_LOG];
            hvld_nxt[cls_r] = 1'b1;
          end
        end
      end
      S_CARVE: begin
        // first block goes out marked, the rest are chained
        if (!k_last || out_free) begin
          hd_we         = 1'b1;
          hd_waddr      = a_r[ADDR_W-1:ALIGN_LOG];
          hd_wdata.mark = (k_r == '0);
          hd_wdata.cls  = pow_r;
          hd_wdata.nvld = (k_r != '0) && !k_last;
          hd_wdata.nidx = ((k_r != '0) && !k_last) ? a_sum[ADDR_W-1:ALIGN_LOG] : '0;
          k_nxt         = k_r + N_W'(1);
          a_nxt         = a_sum[ADDR_W-1:0];
        end
        if (k_last) begin
          fin      = out_free;
          fin_addr = base_r + ADDR_W'(HDR_BYTES);
          fin_cls  = pow_r;
        end
      end
      S_FRD: begin
        if (!hd_rd.mark || (hd_rd.cls >= CLSF_W'(NUM_CLASSES))) begin
          fin        = out_free;
          fin_status = STAT_BAD_MARK;
        end else begin
          cls_nxt   = hd_rd.cls[CLS_W-1:0];
          state_nxt = S_FPUSH;
        end
      end
      S_FPUSH: begin
        fin     = out_free;
        fin_cls = CLSF_W'(cls_r);
        if (out_free) begin
          hd_we           = 1'b1;
          hd_wdata.cls    = CLSF_W'(cls_r);
          hd_wdata.nvld   = hvld_r[cls_r];
          hd_wdata.nidx   = hvld_r[cls_r] ? hl_rdata : '0;
          hl_we           = 1'b1;
          hl_wdata        = idx_r;
          hvld_nxt[cls_r] = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    fin_addr_ext = {{OADDR_W{1'b0}}, fin_addr};
    if (fin) begin
      state_nxt      = S_IDLE;
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = {{OUT_PAD_W{1'b0}}, fin_cls[OCLS_W-1:0],
                        fin_addr_ext[OADDR_W-1:0], fin_status};
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      priority if (cfg_index == CFG_REGION_START) begin
        bp_nxt = reload;
      end else if (cfg_index == CFG_REGION_END) begin
        rend_nxt = cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      bp_r         <= '0;
      rend_r       <= REGION_END_RST;
      hvld_r       <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_r        <= clr_nxt;
      bp_r         <= bp_nxt;
      rend_r       <= rend_nxt;
      hvld_r       <= hvld_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    pow_r       <= pow_nxt;
    big_r       <= big_nxt;
    addr_r      <= addr_nxt;
    cls_r       <= cls_nxt;
    idx_r       <= idx_nxt;
    base_r      <= base_nxt;
    a_r         <= a_nxt;
    blk_r       <= blk_nxt;
    n_r         <= n_nxt;
    k_r         <= k_nxt;
    out_tdata_r <= out_tdata_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

  `P2BA_ASSERT_NOW(a_clear_no_accept, state_r == S_CLEAR, !in_tready, "transfer during clearing pass")
  `P2BA_ASSERT_NXT(a_accept_decode, in_tvalid && in_tready, state_r == S_DECODE, "accepted item not decoded")
  `P2BA_ASSERT_NOW(a_carve_bound, state_r == S_CARVE, k_r < n_r, "carve count overrun")
  `P2BA_ASSERT_NOW(a_fin_slot_free, fin, !out_tvalid_r || out_tready, "result overwrites pending transfer")

endmodule

// ===== hdl/p2ba_ram.sv =====
// generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module p2ba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== bench/power_of_two_bucket_allocator_core_tb.sv =====
// self-checking bench for power_of_two_bucket_allocator_core: directed and random
// alloc/free traffic with random stalls, checked against an in-bench allocator model
// depends on p2ba_pkg and the core rtl
`timescale 1ns / 1ps

module power_of_two_bucket_allocator_core_tb;
  import p2ba_pkg::*;

  localparam int NCLS        = 20;
  localparam int STORE_N     = 1 << 17;
  localparam int QUIET_LIMIT = 600000;
  localparam int SETTLE      = 20;
  localparam longint unsigned SPACE_TOP = 64'd1 << 20;

  typedef enum logic [1:0] {
    REQ_ALLOC,
    REQ_FREE_ADDR,
    REQ_FREE_LIVE,
    REQ_FREE_STALE
  } req_kind_t;

  typedef struct {
    req_kind_t   kind;
    logic [20:0] size;
    logic [19:0] addr;
  } request_t;

  typedef struct packed {
    status_t     status;
    logic [19:0] address;
    logic [4:0]  size_class;
  } alloc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [REG_W-1:0] cfg_wr_data = '0;

  power_of_two_bucket_allocator_core u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  // allocator model state
  bit              hdr_mark [STORE_N];
  bit [5:0]        hdr_cls  [STORE_N];
  bit              hdr_nv   [STORE_N];
  bit [16:0]       hdr_nidx [STORE_N];
  bit              head_v   [NCLS];
  bit [16:0]       head_idx [NCLS];
  longint unsigned brk       = 0;
  longint unsigned reg_start = 0;
  longint unsigned reg_end   = 64'd1048576;

  request_t        request_q[$];
  alloc_result_t   expected_results_q[$];
  logic [19:0]     live_blocks_q[$];
  logic [19:0]     freed_blocks_q[$];
  int              err_cnt = 0;
  int              quiet = 0;
  int              gap_left = 0;
  int              stall_left = 0;
  bit              src_idle_on = 1'b1;
  bit              snk_idle_on = 1'b1;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  function automatic void set_header(logic [16:0] idx, bit mark, bit [5:0] cls, bit nv,
                                     logic [16:0] nidx);
    hdr_mark[idx] = mark;
    hdr_cls[idx]  = cls;
    hdr_nv[idx]   = nv;
    hdr_nidx[idx] = nidx;
  endfunction

  function automatic alloc_result_t serve_request(logic op, logic [20:0] size,
                                                  logic [19:0] baddr);
    alloc_result_t   r;
    int              cls;
    logic [16:0]     idx;
    logic [19:0]     hdr;
    longint unsigned blk, n, total, lim, base, a;
    r = '{status: STAT_OK, address: '0, size_class: '0};
    if (op == OP_ALLOC) begin
      cls = 1;
      while (cls < NCLS && size > (64'd1 << cls)) cls++;
      if (cls >= NCLS) begin
        r.status = STAT_TOO_LARGE;
        return r;
      end
      r.size_class = 5'(cls);
      if (head_v[cls]) begin
        idx = head_idx[cls];
        if (hdr_mark[idx]) begin
          head_v[cls]   = 1'b0;
          head_idx[cls] = '0;
          r.status = STAT_CORRUPT;
          return r;
        end
        head_v[cls]   = hdr_nv[idx];
        head_idx[cls] = hdr_nidx[idx];
        set_header(idx, 1'b1, 6'(cls), 1'b0, '0);
        r.address = 20'({idx, 3'b000} + 24);
        return r;
      end
      blk   = (64'd24 + (64'd1 << cls) + 64'd7) & ~64'd7;
      n     = (cls < CARVE_LIMIT) ? longint'(CARVE_LIMIT - cls + 2) : 64'd1;
      total = blk * n;
      lim   = (reg_end < SPACE_TOP) ? reg_end : SPACE_TOP;
      if (brk > lim || total > lim - brk) begin
        r.status = STAT_NO_SPACE;
        return r;
      end
      base = brk;
      brk  = brk + total;
      set_header(17'(base >> 3), 1'b1, 6'(cls), 1'b0, '0);
      for (longint unsigned k = 1; k < n; k++) begin
        a = base + k * blk;
        if (k + 1 < n) set_header(17'(a >> 3), 1'b0, 6'(cls), 1'b1, 17'((a + blk) >> 3));
        else set_header(17'(a >> 3), 1'b0, 6'(cls), 1'b0, '0);
      end
      if (n > 1) begin
        head_v[cls]   = 1'b1;
        head_idx[cls] = 17'((base + blk) >> 3);
      end
      r.address = 20'(base + 24);
    end else begin
      if (baddr == '0) return r;
      hdr = baddr - 20'd24;
      if (hdr[2:0] != 3'b000) begin
        r.status = STAT_BAD_MARK;
        return r;
      end
      idx = hdr[19:3];
      if (!hdr_mark[idx] || hdr_cls[idx] >= NCLS) begin
        r.status = STAT_BAD_MARK;
        return r;
      end
      cls = hdr_cls[idx];
      set_header(idx, 1'b0, hdr_cls[idx], head_v[cls], head_idx[cls]);
      head_v[cls]   = 1'b1;
      head_idx[cls] = idx;
      r.size_class  = 5'(cls);
    end
    return r;
  endfunction

  // register writes update the model when the core takes them
  always @(posedge clk) begin
    if (rst_n && cfg_wr_en) begin
      if (cfg_index == CFG_REGION_START) begin
        reg_start = cfg_wr_data;
        brk = (reg_start + 64'd7) & ~64'd7;
      end else begin
        reg_end = cfg_wr_data;
      end
    end
  end

  // request driver
  always @(posedge clk) begin : drv
    request_t      req;
    alloc_result_t res;
    logic [19:0]   a;
    int            pos;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      gap_left  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        res = serve_request(in_tuser, in_tdata[20:0], in_tdata[40:21]);
        expected_results_q.push_back(res);
        if (res.status == STAT_OK && in_tuser == OP_ALLOC) begin
          live_blocks_q.push_back(res.address);
        end else if (res.status == STAT_OK && in_tdata[40:21] != '0) begin
          pos = -1;
          foreach (live_blocks_q[i]) if (pos < 0 && live_blocks_q[i] == in_tdata[40:21]) pos = i;
          if (pos >= 0) live_blocks_q.delete(pos);
          freed_blocks_q.push_back(in_tdata[40:21]);
          if (freed_blocks_q.size() > 32) void'(freed_blocks_q.pop_front());
        end
      end
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          gap_left  <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (src_idle_on && $urandom_range(0, 4) == 0) begin
          gap_left  <= $urandom_range(0, 4);
          in_tvalid <= 1'b0;
        end else if (request_q.size() != 0) begin
          req = request_q.pop_front();
          a = req.addr;
          if (req.kind == REQ_FREE_LIVE && live_blocks_q.size() != 0)
            a = live_blocks_q[$urandom_range(0, live_blocks_q.size() - 1)];
          else if (req.kind == REQ_FREE_STALE && freed_blocks_q.size() != 0)
            a = freed_blocks_q[$urandom_range(0, freed_blocks_q.size() - 1)];
          in_tvalid <= 1'b1;
          in_tuser  <= (req.kind == REQ_ALLOC) ? OP_ALLOC : OP_FREE;
          in_tdata  <= IN_TDATA_W'({a, req.size});
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk) begin : mon
    alloc_result_t got, want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = '{status: status_t'(out_tdata[2:0]), address: out_tdata[22:3],
                size_class: out_tdata[27:23]};
        if (expected_results_q.size() == 0) begin
          $display("%0t: unexpected result status %0d address %0h class %0d",
                   $time, got.status, got.address, got.size_class);
          err_cnt++;
        end else begin
          want = expected_results_q.pop_front();
          if (got.status != want.status || got.address != want.address ||
              got.size_class != want.size_class) begin
            $display("%0t: mismatch expected status %0d address %0h class %0d, actual status %0d address %0h class %0d",
                     $time, want.status, want.address, want.size_class,
                     got.status, got.address, got.size_class);
            err_cnt++;
          end
        end
      end
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
        out_tready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 4) == 0) begin
        stall_left <= $urandom_range(0, 4);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog: cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("power_of_two_bucket_allocator_core_tb failed");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] data);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic set_region(logic [REG_W-1:0] start_b, logic [REG_W-1:0] end_b);
    write_reg(CFG_REGION_START, start_b);
    write_reg(CFG_REGION_END, end_b);
    @(negedge clk);
  endtask

  task automatic wait_for_idle();
    do @(negedge clk);
    while (request_q.size() != 0 || in_tvalid || expected_results_q.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  function automatic void add_alloc(logic [20:0] size);
    request_q.push_back('{kind: REQ_ALLOC, size: size, addr: '0});
  endfunction

  function automatic void add_free(req_kind_t kind, logic [19:0] addr);
    request_q.push_back('{kind: kind, size: 21'($urandom), addr: addr});
  endfunction

  function automatic logic [20:0] random_size();
    int r, c;
    r = $urandom_range(0, 99);
    if (r < 4) return 21'($urandom_range(524289, 2097151));
    if (r < 8) c = $urandom_range(15, 19);
    else if (r < 30) c = $urandom_range(9, 14);
    else c = $urandom_range(1, 8);
    if (c == 1) return 21'($urandom_range(0, 2));
    return 21'($urandom_range((1 << (c - 1)) + 1, 1 << c));
  endfunction

  function automatic void add_random_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) add_alloc(random_size());
    else if (r < 85) add_free(REQ_FREE_LIVE, 20'($urandom));
    else if (r < 91) add_free(REQ_FREE_STALE, 20'($urandom));
    else if (r < 96) add_free(REQ_FREE_ADDR, 20'($urandom));
    else add_free(REQ_FREE_ADDR, '0);
  endfunction

  initial begin
    logic [REG_W-1:0] s, e;
    wait (rst_n === 1'b1);
    set_region(21'd0, REGION_END_RST);
    // size extremes, every class boundary kind, space exhaustion
    add_alloc(21'd0);
    add_alloc(21'd1);
    add_alloc(21'd2);
    add_alloc(21'd3);
    add_alloc(21'd4096);
    add_alloc(21'd4097);
    add_alloc(21'd524288);
    add_alloc(21'd524289);
    add_alloc(21'h1FFFFF);
    add_alloc(21'd524288);
    // free paths: good, double, no-op, unaligned, wrapped header address
    add_free(REQ_FREE_ADDR, 20'd24);
    add_free(REQ_FREE_ADDR, 20'd24);
    add_free(REQ_FREE_ADDR, 20'd0);
    add_free(REQ_FREE_ADDR, 20'd25);
    add_free(REQ_FREE_ADDR, 20'hFFFFF);
    add_free(REQ_FREE_ADDR, 20'd16);
    add_alloc(21'd1);
    wait_for_idle();
    // unaligned start, end past the address space
    set_region(21'd600001, 21'h1FFFFF);
    add_alloc(21'd8);
    wait_for_idle();
    // restart inside the class 3 chain so its next head is overwritten by a marked header
    set_region(21'd600040, 21'h1FFFFF);
    add_alloc(21'd16);
    add_alloc(21'd8);
    add_alloc(21'd8);
    add_alloc(21'd262144);
    add_alloc(21'd262144);
    wait_for_idle();
    // break past the end, zero end
    set_region(21'h1FFFFF, 21'd0);
    add_alloc(21'd100);
    add_alloc(21'd2);
    add_free(REQ_FREE_LIVE, 20'd0);
    wait_for_idle();

    for (int p = 0; p < 5; p++) begin
      case ($urandom_range(0, 3))
        0: s = 21'd0;
        1: s = 21'($urandom_range(0, 524288)) & ~21'd7;
        default: s = 21'($urandom_range(0, 524288));
      endcase
      case ($urandom_range(0, 2))
        0: e = REGION_END_RST;
        1: e = 21'h1FFFFF;
        default: e = s + 21'($urandom_range(65536, 524288));
      endcase
      if (p == 4) begin
        s = 21'd0;
        e = REGION_END_RST;
      end
      set_region(s, e);
      src_idle_on = (p != 1 && p != 4);
      snk_idle_on = (p != 2 && p != 4);
      repeat (110) add_random_request();
      wait_for_idle();
    end

    if (err_cnt == 0) begin
      $display("power_of_two_bucket_allocator_core_tb passed");
    end else begin
      $display("power_of_two_bucket_allocator_core_tb failed");
    end
    $finish;
  end

endmodule
